// ----- hdl/rrd_pkg.sv -----
// rrd_pkg: shared constants, control structs and helper function for the
// run-length row decoder; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rrd_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 32;
    localparam int LANES       = WORD_W / BYTE_W;
    localparam int VALID_W     = 3;
    localparam int COUNT_W     = 7;
    localparam int ROW_WIDTH_W = 13;
    localparam int CFG_DATA_W  = ROW_WIDTH_W;
    localparam int CFG_INDEX_W = 1;
    localparam int RES_LIMIT   = 32;
    localparam int RES_CNT_W   = $clog2(RES_LIMIT);

    localparam int MAX_ROW_WIDTH_DEF = 4096;
    localparam int PACK_BYTES_DEF    = 4;

    localparam logic                   RLE_MODE_RST  = 1'b1;
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 13'd256;

    localparam logic [CFG_INDEX_W-1:0] CFG_RLE_MODE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_WIDTH = 1'b1;

    typedef struct packed {
        logic in_ready;
        logic accept;
        logic emit_next;
    } rrd_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic multi;
        logic pend_last;
    } rrd_status_t;

    function automatic logic [WORD_W-1:0] rep_word(input logic [BYTE_W-1:0]  b,
                                                    input logic [VALID_W-1:0] n);
        logic [WORD_W-1:0] w;
        w = '0;
        for (int i = 0; i < LANES; i++)
        begin
            if (VALID_W'(i) < n)
            begin
                w[i*BYTE_W +: BYTE_W] = b;
            end
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/rrd_if.sv -----
// rrd_in_if / rrd_out_if: valid/ready channels for coded bytes and
// decoded results; depends on rrd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rrd_in_if import rrd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              row_start;

    modport source (output valid, output data_byte, output row_start, input ready);
    modport sink   (input valid, input data_byte, input row_start, output ready);
endinterface

interface rrd_out_if import rrd_pkg::*;;
    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  pixel_word;
    logic [VALID_W-1:0] valid_bytes;
    logic               run_last;
    logic               row_end;
    logic               overflow;

    modport source (output valid, output pixel_word, output valid_bytes,
                    output run_last, output row_end, output overflow, input ready);
    modport sink   (input valid, input pixel_word, input valid_bytes,
                    input run_last, input row_end, input overflow, output ready);
endinterface

`default_nettype wire

// ----- hdl/rrd_ctrl.sv -----
// rrd_ctrl: controller that accepts requests and sequences the result burst
// of a run; depends on rrd_pkg
`timescale 1ns / 1ps
`default_nettype none

module rrd_ctrl import rrd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire rrd_status_t status,
    output rrd_cmd_t         cmd
);

    typedef enum logic {ST_IDLE, ST_EMIT} state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd.in_ready  = (state_reg == ST_IDLE) && status.slot_free;
        cmd.accept    = cmd.in_ready && in_valid;
        cmd.emit_next = (state_reg == ST_EMIT) && status.slot_free;
        state_next    = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept && status.multi)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (cmd.emit_next && status.pend_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/rrd_datapath.sv -----
// rrd_datapath: configuration, row state, result packer and output register
// depends on rrd_pkg
`timescale 1ns / 1ps
`default_nettype none

module rrd_datapath import rrd_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF,
    parameter int PACK_BYTES    = PACK_BYTES_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [BYTE_W-1:0]      data_byte,
    input  wire logic                   row_start,
    input  wire logic                   out_ready,
    input  wire rrd_cmd_t               cmd,
    output rrd_status_t                 status,
    output logic                        out_valid,
    output logic [WORD_W-1:0]           pixel_word,
    output logic [VALID_W-1:0]          valid_bytes,
    output logic                        run_last,
    output logic                        row_end,
    output logic                        overflow
);

    localparam int POS_W    = (MAX_ROW_WIDTH >= (1 << ROW_WIDTH_W) - 1) ? ROW_WIDTH_W
                              : $clog2(MAX_ROW_WIDTH + 1);
    localparam int LANE_MAX = (PACK_BYTES < LANES) ? PACK_BYTES : LANES;
    localparam logic [COUNT_W-1:0] PACK_L = COUNT_W'(PACK_BYTES);
    localparam logic [COUNT_W-1:0] LANE_L = COUNT_W'(LANE_MAX);

    typedef enum logic [1:0] {PH_HEADER, PH_LITERAL, PH_RUN, PH_DONE} phase_t;

    // configuration
    logic                   rle_mode_reg;
    logic [ROW_WIDTH_W-1:0] row_width_reg;

    // row state
    phase_t             phase_reg,  phase_next;
    logic [COUNT_W-1:0] count_reg,  count_next;
    logic [POS_W-1:0]   pos_reg,    pos_next;
    logic               ovf_reg,    ovf_next;

    // burst state
    logic [BYTE_W-1:0]    emit_byte_reg, emit_byte_next;
    logic [COUNT_W-1:0]   emit_left_reg, emit_left_next;
    logic [RES_CNT_W-1:0] emit_cnt_reg,  emit_cnt_next;
    logic                 emit_end_reg,  emit_end_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]  word_reg,      word_next;
    logic [VALID_W-1:0] vb_reg,        vb_next;
    logic               last_reg,      last_next;
    logic               end_reg,       end_next;
    logic               oflag_reg,     oflag_next;

    // request decode
    phase_t             ph0,  ph_upd;
    logic [COUNT_W-1:0] cnt0, cnt_upd, cnt_dec;
    logic [POS_W-1:0]   pos0, pos_upd, width_eff, room;
    logic               ovf0, ovf_upd;
    logic               do_emit, zero_hdr, verbatim, end_flag;
    logic [COUNT_W-1:0] n, m;
    logic [VALID_W-1:0] first_vb, next_vb;
    logic               first_last, next_last;
    logic               load_first;

    always_comb
    begin
        ph0  = row_start ? PH_HEADER : phase_reg;
        cnt0 = row_start ? '0 : count_reg;
        pos0 = row_start ? '0 : pos_reg;
        ovf0 = row_start ? 1'b0 : ovf_reg;

        ph_upd   = ph0;
        cnt_upd  = cnt0;
        cnt_dec  = (cnt0 != '0) ? cnt0 - 1'b1 : '0;
        do_emit  = 1'b0;
        zero_hdr = 1'b0;
        verbatim = 1'b0;
        n        = '0;

        if (!rle_mode_reg)
        begin
            do_emit  = 1'b1;
            verbatim = 1'b1;
            n        = COUNT_W'(1);
        end
        else
        begin
            case (ph0)
                PH_HEADER:
                begin
                    if (data_byte[COUNT_W-1:0] == '0)
                    begin
                        zero_hdr = 1'b1;
                        ph_upd   = PH_DONE;
                    end
                    else
                    begin
                        cnt_upd = data_byte[COUNT_W-1:0];
                        ph_upd  = data_byte[BYTE_W-1] ? PH_LITERAL : PH_RUN;
                    end
                end
                PH_LITERAL:
                begin
                    cnt_upd = cnt_dec;
                    ph_upd  = (cnt_dec == '0) ? PH_HEADER : PH_LITERAL;
                    do_emit = 1'b1;
                    n       = COUNT_W'(1);
                end
                PH_RUN:
                begin
                    cnt_upd = '0;
                    ph_upd  = PH_HEADER;
                    do_emit = 1'b1;
                    n       = cnt0;
                end
                default:
                begin
                    ph_upd = ph0;
                end
            endcase
        end

        // clamp width and fit the request into the room left in the row
        if (32'(row_width_reg) > MAX_ROW_WIDTH)
        begin
            width_eff = POS_W'(MAX_ROW_WIDTH);
        end
        else
        begin
            width_eff = POS_W'(row_width_reg);
        end
        room     = (pos0 < width_eff) ? width_eff - pos0 : '0;
        m        = (32'(n) < 32'(room)) ? n : COUNT_W'(room);
        pos_upd  = do_emit ? pos0 + POS_W'(m) : pos0;
        ovf_upd  = ovf0 | (do_emit && (m < n));
        end_flag = verbatim && (m != '0) && (pos_upd == width_eff);

        first_vb   = (m < LANE_L) ? VALID_W'(m) : VALID_W'(LANE_L);
        first_last = (m <= PACK_L);

        next_vb   = (emit_left_reg < LANE_L) ? VALID_W'(emit_left_reg) : VALID_W'(LANE_L);
        next_last = (emit_left_reg <= PACK_L) || (emit_cnt_reg == RES_CNT_W'(RES_LIMIT - 1));

        status.slot_free = !out_valid_reg || out_ready;
        status.multi     = do_emit && (m > PACK_L);
        status.pend_last = next_last;

        load_first = cmd.accept && (do_emit || zero_hdr);

        phase_next = cmd.accept ? ph_upd  : phase_reg;
        count_next = cmd.accept ? cnt_upd : count_reg;
        pos_next   = cmd.accept ? pos_upd : pos_reg;
        ovf_next   = cmd.accept ? ovf_upd : ovf_reg;

        emit_byte_next = emit_byte_reg;
        emit_left_next = emit_left_reg;
        emit_cnt_next  = emit_cnt_reg;
        emit_end_next  = emit_end_reg;
        word_next      = word_reg;
        vb_next        = vb_reg;
        last_next      = last_reg;
        end_next       = end_reg;
        oflag_next     = oflag_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        if (load_first)
        begin
            out_valid_next = 1'b1;
            oflag_next     = ovf_upd;
            emit_byte_next = data_byte;
            emit_left_next = (m > PACK_L) ? m - PACK_L : '0;
            emit_cnt_next  = RES_CNT_W'(1);
            emit_end_next  = end_flag;
            if (zero_hdr)
            begin
                word_next = '0;
                vb_next   = '0;
                last_next = 1'b1;
                end_next  = 1'b1;
            end
            else
            begin
                word_next = rep_word(data_byte, first_vb);
                vb_next   = first_vb;
                last_next = first_last;
                end_next  = first_last && end_flag;
            end
        end
        else if (cmd.emit_next)
        begin
            out_valid_next = 1'b1;
            oflag_next     = ovf_reg;
            word_next      = rep_word(emit_byte_reg, next_vb);
            vb_next        = next_vb;
            last_next      = next_last;
            end_next       = next_last && emit_end_reg;
            emit_left_next = (emit_left_reg > PACK_L) ? emit_left_reg - PACK_L : '0;
            emit_cnt_next  = emit_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rle_mode_reg  <= RLE_MODE_RST;
            row_width_reg <= ROW_WIDTH_RST;
            phase_reg     <= PH_HEADER;
            count_reg     <= '0;
            pos_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RLE_MODE:  rle_mode_reg  <= cfg_data[0];
                    CFG_ROW_WIDTH: row_width_reg <= cfg_data;
                    default:       rle_mode_reg  <= rle_mode_reg;
                endcase
            end
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        emit_byte_reg <= emit_byte_next;
        emit_left_reg <= emit_left_next;
        emit_cnt_reg  <= emit_cnt_next;
        emit_end_reg  <= emit_end_next;
        word_reg      <= word_next;
        vb_reg        <= vb_next;
        last_reg      <= last_next;
        end_reg       <= end_next;
        oflag_reg     <= oflag_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_word  = word_reg;
    assign valid_bytes = vb_reg;
    assign run_last    = last_reg;
    assign row_end     = end_reg;
    assign overflow    = oflag_reg;

endmodule

`default_nettype wire

// ----- hdl/rle_row_decoder.sv -----
// The first result of a request is registered and shown in the cycle after it is taken.
// Requests giving at most one result (headers, literals, verbatim bytes): one request per
// cycle while the output is not stalled. A run of n kept bytes yields ceil(n / PACK_BYTES)
// results, at most 32, loaded by the packer one per cycle unless stalled; the input waits.
// Reset clears the row state and the output valid flag, rle_mode to 1, row_width to 256.
// rle_row_decoder: top level; depends on rrd_pkg, rrd_if, rrd_ctrl, rrd_datapath
`timescale 1ns / 1ps
`default_nettype none

module rle_row_decoder import rrd_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF,
    parameter int PACK_BYTES    = PACK_BYTES_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    rrd_in_if.sink                      in_ch,
    rrd_out_if.source                   out_ch
);

    rrd_cmd_t    cmd;
    rrd_status_t status;

    rrd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .status   (status),
        .cmd      (cmd)
    );

    rrd_datapath
    #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
        .PACK_BYTES    (PACK_BYTES)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .data_byte   (in_ch.data_byte),
        .row_start   (in_ch.row_start),
        .out_ready   (out_ch.ready),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_ch.valid),
        .pixel_word  (out_ch.pixel_word),
        .valid_bytes (out_ch.valid_bytes),
        .run_last    (out_ch.run_last),
        .row_end     (out_ch.row_end),
        .overflow    (out_ch.overflow)
    );

    assign in_ch.ready = cmd.in_ready;

endmodule

`default_nettype wire

// ----- hdl/rrd_checker.sv -----
// rrd_checker: port-level assertions for rle_row_decoder, bound to the top level
// depends on rrd_pkg
`timescale 1ns / 1ps
`default_nettype none

module rrd_checker import rrd_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [WORD_W-1:0]  pixel_word,
    input wire logic [VALID_W-1:0] valid_bytes,
    input wire logic               run_last,
    input wire logic               row_end
);

    // a held result stays put until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_word) && $stable(valid_bytes))
        else $error("result changed while stalled");

    // no new request while a burst still has results to come
    a_burst_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |-> !in_ready)
        else $error("request taken inside a burst");

    a_lanes_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> valid_bytes <= VALID_W'(LANES))
        else $error("valid_bytes out of range");

    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (valid_bytes == '0) |-> pixel_word == '0)
        else $error("empty result with nonzero data");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && row_end |-> run_last)
        else $error("row end on a non-final result");

endmodule

bind rle_row_decoder rrd_checker u_rrd_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .pixel_word  (out_ch.pixel_word),
    .valid_bytes (out_ch.valid_bytes),
    .run_last    (out_ch.run_last),
    .row_end     (out_ch.row_end)
);

`default_nettype wire
